// ===== design/sdsc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdsc_pkg
// types, codes and frame helpers shared by the sd spi command engine
// ----------------------------------------------------------------------------
`default_nettype none

package sdsc_pkg;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 56;

   // operation codes on the request tuser
   localparam logic OP_START  = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   // response kinds
   localparam logic [2:0] KIND_R1  = 3'd0;
   localparam logic [2:0] KIND_R1B = 3'd1;
   localparam logic [2:0] KIND_R2  = 3'd2;
   localparam logic [2:0] KIND_R7  = 3'd4;

   // command indexes with a fixed crc
   localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
   localparam logic [5:0] CMD_IF_COND  = 6'd8;

   localparam logic [7:0] CMD_START_MARK = 8'h40;
   localparam logic [5:0] CMD_INDEX_MASK = 6'h3F;
   localparam logic [7:0] CRC_GO_IDLE    = 8'h95;
   localparam logic [7:0] CRC_IF_COND    = 8'h87;
   localparam logic [7:0] CRC_OTHER      = 8'h8E;
   localparam logic [7:0] START_BIT_MASK = 8'h80;
   localparam logic [7:0] FILLER_BYTE    = 8'hFF;

   localparam logic [15:0] TIMEOUT_RESET = 16'd100;
   localparam logic [15:0] POLL_MAX      = 16'hFFFF;

   localparam logic [2:0] LAST_FRAME_POS = 3'd5;
   localparam logic [2:0] MAX_RESP_BYTES = 3'd5;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SEND,
      PH_POLL,
      PH_GATHER,
      PH_BUSY,
      PH_FINAL
   } phase_type;

   typedef struct packed {
      logic        operation;
      logic [5:0]  command_index;
      logic [31:0] argument_value;
      logic [2:0]  response_kind;
      logic [7:0]  rx_byte;
   } item_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        chip_select;
      logic        done_res;
      logic        timed_out;
      logic [39:0] response_data;
      logic [2:0]  response_count;
   } result_type;

   typedef struct packed {
      phase_type phase;
   } core_status_type;

   // number of response bytes gathered for a kind, zero for kinds above r7
   function automatic logic [2:0] resp_len(input logic [2:0] kind);
      logic [2:0] len;
      if (kind <= KIND_R1B) begin
         len = 3'd1;
      end else if (kind == KIND_R2) begin
         len = 3'd2;
      end else if (kind <= KIND_R7) begin
         len = 3'd5;
      end else begin
         len = 3'd0;
      end
      return len;
   endfunction

   // byte of the six byte command frame at a position
   function automatic logic [7:0] frame_byte(input logic [2:0]  pos,
                                             input logic [5:0]  cmd,
                                             input logic [31:0] arg);
      logic [7:0] b;
      case (pos)
         3'd0: b = CMD_START_MARK | {2'b00, cmd & CMD_INDEX_MASK};
         3'd1: b = arg[31:24];
         3'd2: b = arg[23:16];
         3'd3: b = arg[15:8];
         3'd4: b = arg[7:0];
         default: begin
            if (cmd == CMD_GO_IDLE) begin
               b = CRC_GO_IDLE;
            end else if (cmd == CMD_IF_COND) begin
               b = CRC_IF_COND;
            end else begin
               b = CRC_OTHER;
            end
         end
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== design/sd_spi_command_engine.sv =====
// ----------------------------------------------------------------------------
// sd_spi_command_engine
// host side sequencer for one sd card spi-mode command exchange
// ----------------------------------------------------------------------------
// a request beat is held in the input register, stepped through the combinational
// sequencer step and loaded into the result register, which offers its response
// beat; throughput: one beat per cycle while the response side does not stall
// reset: synchronous, clears both stages, sequencer goes idle, timeout = 100
`default_nettype none

module sd_spi_command_engine (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // command_index[5:0], argument_value[37:6], response_kind[40:38],
   // rx_byte[48:41], zero fill above
   input  wire logic [sdsc_pkg::REQ_TDATA_W-1:0] req_tdata,
   // operation[0]
   input  wire logic                             req_tuser,
   // response channel
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // tx_valid[0], tx_byte[8:1], chip_select[9], done_res[10], timed_out[11],
   // response_data[51:12], response_count[54:52], zero fill above
   output logic [sdsc_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // timeout register write
   input  wire logic                             csr_wr_en,
   input  wire logic [15:0]                      csr_wr_data
);

   sdsc_pkg::item_type        req_item;
   sdsc_pkg::item_type        held_item;
   logic                      held_valid;
   logic                      step_ready;
   logic                      step_en;
   sdsc_pkg::result_type      step_result;
   sdsc_pkg::result_type      rsp_result;
   sdsc_pkg::core_status_type core_status;

   // unpack the request beat
   assign req_item.operation      = req_tuser;
   assign req_item.command_index  = req_tdata[5:0];
   assign req_item.argument_value = req_tdata[37:6];
   assign req_item.response_kind  = req_tdata[40:38];
   assign req_item.rx_byte        = req_tdata[48:41];

   // input register: takes a new beat when it is empty or the beat it holds moves on
   sdsc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_tvalid),
      .up_ready   (req_tready),
      .up_item    (req_item),
      .down_valid (held_valid),
      .down_ready (step_ready),
      .down_item  (held_item)
   );

   // the sequencer advances exactly when its result is loaded downstream
   assign step_en = held_valid && step_ready;

   sdsc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step_en     (step_en),
      .item        (held_item),
      .result      (step_result),
      .status      (core_status)
   );

   // result register: parts the sequencer from a stalled response side
   sdsc_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .up_valid    (held_valid),
      .up_ready    (step_ready),
      .up_result   (step_result),
      .down_valid  (rsp_tvalid),
      .down_ready  (rsp_tready),
      .down_result (rsp_result)
   );

   // pack the response beat
   assign rsp_tdata = {1'b0,
                       rsp_result.response_count,
                       rsp_result.response_data,
                       rsp_result.timed_out,
                       rsp_result.done_res,
                       rsp_result.chip_select,
                       rsp_result.tx_byte,
                       rsp_result.tx_valid};

   // chip select follows the request for another exchange on every beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_result.chip_select == rsp_result.tx_valid))
      else $error("chip select disagrees with tx_valid");

   // a finishing step always leaves the sequencer idle
   assert property (@(posedge clock) disable iff (reset)
      (step_en && step_result.done_res) |=> (core_status.phase == sdsc_pkg::PH_IDLE))
      else $error("sequencer not idle after finishing step");

   // a timeout carries no response bytes and always finishes the command
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_result.timed_out) |->
         (rsp_result.done_res && rsp_result.response_count == 3'd0))
      else $error("timeout beat malformed");

endmodule

`default_nettype wire

// ===== design/sdsc_in_reg.sv =====
// ----------------------------------------------------------------------------
// sdsc_in_reg
// input register stage holding one request beat
// ----------------------------------------------------------------------------
`default_nettype none

module sdsc_in_reg (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               up_valid,
   output logic                    up_ready,
   input  wire sdsc_pkg::item_type up_item,
   output logic                    down_valid,
   input  wire logic               down_ready,
   output sdsc_pkg::item_type      down_item
);

   logic               valid_ff;
   logic               valid_in;
   sdsc_pkg::item_type item_ff;

   assign up_ready   = !valid_ff || down_ready;
   assign valid_in   = up_ready ? up_valid : valid_ff;
   assign down_valid = valid_ff;
   assign down_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         item_ff <= up_item;
      end
   end

endmodule

`default_nettype wire

// ===== design/sdsc_core.sv =====
// ----------------------------------------------------------------------------
// sdsc_core
// command sequencer: holds the exchange state and turns one beat into a result
// ----------------------------------------------------------------------------
`default_nettype none

module sdsc_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wr_en,
   input  wire logic [15:0]             csr_wr_data,
   input  wire logic                    step_en,
   input  wire sdsc_pkg::item_type      item,
   output sdsc_pkg::result_type         result,
   output sdsc_pkg::core_status_type    status
);

   sdsc_pkg::phase_type phase_ff, phase_in;
   logic [2:0]          pos_ff, pos_in;
   logic [15:0]         poll_ff, poll_in;
   logic [5:0]          cmd_ff, cmd_in;
   logic [31:0]         arg_ff, arg_in;
   logic [2:0]          kind_ff, kind_in;
   logic [39:0]         gathered_ff, gathered_in;
   logic [15:0]         timeout_ff;

   logic [2:0]          len;
   logic [15:0]         poll_next;
   logic [7:0]          rx;

   assign status.phase = phase_ff;
   assign len          = sdsc_pkg::resp_len(kind_ff);
   assign rx           = item.rx_byte;
   // poll counter saturates
   assign poll_next    = (poll_ff == sdsc_pkg::POLL_MAX) ? poll_ff : poll_ff + 16'd1;

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      poll_in     = poll_ff;
      cmd_in      = cmd_ff;
      arg_in      = arg_ff;
      kind_in     = kind_ff;
      gathered_in = gathered_ff;
      result      = '0;

      if (item.operation == sdsc_pkg::OP_START) begin
         cmd_in             = item.command_index;
         arg_in             = item.argument_value;
         kind_in            = item.response_kind;
         phase_in           = sdsc_pkg::PH_SEND;
         pos_in             = 3'd0;
         poll_in            = 16'd0;
         gathered_in        = '0;
         result.tx_valid    = 1'b1;
         result.chip_select = 1'b1;
         result.tx_byte     = sdsc_pkg::frame_byte(3'd0, item.command_index,
                                                   item.argument_value);
      end else begin
         case (phase_ff)
            sdsc_pkg::PH_SEND: begin
               result.tx_valid    = 1'b1;
               result.chip_select = 1'b1;
               if (pos_ff < sdsc_pkg::LAST_FRAME_POS) begin
                  pos_in         = pos_ff + 3'd1;
                  result.tx_byte = sdsc_pkg::frame_byte(pos_ff + 3'd1, cmd_ff, arg_ff);
               end else begin
                  phase_in       = sdsc_pkg::PH_POLL;
                  poll_in        = 16'd0;
                  pos_in         = 3'd0;
                  result.tx_byte = sdsc_pkg::FILLER_BYTE;
               end
            end
            sdsc_pkg::PH_POLL: begin
               poll_in = poll_next;
               if ((rx & sdsc_pkg::START_BIT_MASK) == 8'h00) begin
                  if (len == 3'd0) begin
                     // unknown kind ends on the start-bit byte
                     gathered_in     = '0;
                     pos_in          = 3'd0;
                     phase_in        = sdsc_pkg::PH_IDLE;
                     result.done_res = 1'b1;
                  end else begin
                     gathered_in        = {32'd0, rx};
                     pos_in             = 3'd1;
                     phase_in           = sdsc_pkg::PH_GATHER;
                     result.tx_valid    = 1'b1;
                     result.chip_select = 1'b1;
                     result.tx_byte     = sdsc_pkg::FILLER_BYTE;
                  end
               end else if (poll_next >= timeout_ff) begin
                  phase_in         = sdsc_pkg::PH_IDLE;
                  pos_in           = 3'd0;
                  gathered_in      = '0;
                  result.done_res  = 1'b1;
                  result.timed_out = 1'b1;
               end else begin
                  result.tx_valid    = 1'b1;
                  result.chip_select = 1'b1;
                  result.tx_byte     = sdsc_pkg::FILLER_BYTE;
               end
            end
            sdsc_pkg::PH_GATHER: begin
               if (pos_ff < len && pos_ff < sdsc_pkg::MAX_RESP_BYTES) begin
                  gathered_in        = gathered_ff | ({32'd0, rx} << {pos_ff, 3'b000});
                  pos_in             = pos_ff + 3'd1;
                  result.tx_valid    = 1'b1;
                  result.chip_select = 1'b1;
                  result.tx_byte     = sdsc_pkg::FILLER_BYTE;
               end else if (kind_ff == sdsc_pkg::KIND_R1B) begin
                  phase_in           = sdsc_pkg::PH_BUSY;
                  result.tx_valid    = 1'b1;
                  result.chip_select = 1'b1;
                  result.tx_byte     = sdsc_pkg::FILLER_BYTE;
               end else begin
                  phase_in              = sdsc_pkg::PH_IDLE;
                  result.done_res       = 1'b1;
                  result.response_data  = gathered_ff;
                  result.response_count = pos_ff;
               end
            end
            sdsc_pkg::PH_BUSY: begin
               if (rx == sdsc_pkg::FILLER_BYTE) begin
                  phase_in = sdsc_pkg::PH_FINAL;
               end
               result.tx_valid    = 1'b1;
               result.chip_select = 1'b1;
               result.tx_byte     = sdsc_pkg::FILLER_BYTE;
            end
            sdsc_pkg::PH_FINAL: begin
               phase_in              = sdsc_pkg::PH_IDLE;
               result.done_res       = 1'b1;
               result.response_data  = gathered_ff;
               result.response_count = pos_ff;
            end
            default: begin
               phase_in = sdsc_pkg::PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= sdsc_pkg::PH_IDLE;
         pos_ff      <= 3'd0;
         poll_ff     <= 16'd0;
         cmd_ff      <= 6'd0;
         arg_ff      <= 32'd0;
         kind_ff     <= 3'd0;
         gathered_ff <= 40'd0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         poll_ff     <= poll_in;
         cmd_ff      <= cmd_in;
         arg_ff      <= arg_in;
         kind_ff     <= kind_in;
         gathered_ff <= gathered_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= sdsc_pkg::TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/sdsc_out_reg.sv =====
// ----------------------------------------------------------------------------
// sdsc_out_reg
// result register stage feeding the response channel
// ----------------------------------------------------------------------------
`default_nettype none

module sdsc_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 up_valid,
   output logic                      up_ready,
   input  wire sdsc_pkg::result_type up_result,
   output logic                      down_valid,
   input  wire logic                 down_ready,
   output sdsc_pkg::result_type      down_result
);

   logic                 valid_ff;
   logic                 valid_in;
   sdsc_pkg::result_type result_ff;

   assign up_ready    = !valid_ff || down_ready;
   assign valid_in    = up_ready ? up_valid : valid_ff;
   assign down_valid  = valid_ff;
   assign down_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         result_ff <= up_result;
      end
   end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sd spi command engine. A scoreboard class keeps
// its own copy of the sequencer state and the timeout register. It predicts
// one response beat for every accepted request beat and checks each response
// beat field by field. The stimulus runs whole command exchanges with random
// content: frame, polling, gathering, busy wait and trailing byte. Some
// exchanges are abandoned or broken. The sender works in bursts and the
// receiver stalls, and the timeout register is swept between phases.
// ----------------------------------------------------------------------------
module tb_top;
   import sdsc_pkg::*;

   localparam int CLK_HALF     = 5;
   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_BEATS = 1000;
   localparam int RANDOM_PHASES = 8;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 4;    // input and result registers plus margin
   localparam int MAX_REPORTS  = 10;

   // timeout for the closing run that polls until every try is used
   localparam logic [15:0] STEADY_TIMEOUT = 16'd40;

   // kind not named in the package
   localparam logic [2:0] KIND_R3 = 3'd3;

   // -------------------------------------------------------------------------
   // scoreboard: sequencer predictor plus queue of expected response beats
   // -------------------------------------------------------------------------
   class spi_exchange_checker;
      result_type  pending_results[$];
      logic [15:0] timeout_limit;
      phase_type   phase;
      logic [2:0]  byte_pos;
      logic [15:0] poll_count;
      logic [5:0]  cmd;
      logic [31:0] arg;
      logic [2:0]  kind;
      logic [39:0] gathered;
      int          mismatches;
      int          beats_checked;
      int          done_count;
      int          timeout_count;
      int          length_hist[8];

      function new();
         timeout_limit = TIMEOUT_RESET;
         phase         = PH_IDLE;
         byte_pos      = '0;
         poll_count    = '0;
         cmd           = '0;
         arg           = '0;
         kind          = '0;
         gathered      = '0;
         mismatches    = 0;
         beats_checked = 0;
         done_count    = 0;
         timeout_count = 0;
         foreach (length_hist[i]) length_hist[i] = 0;
      endfunction

      // byte of the six byte command frame
      function logic [7:0] frame_out(logic [2:0] pos);
         logic [7:0] b;
         case (pos)
            3'd0: b = CMD_START_MARK | {2'b00, cmd};
            3'd1: b = arg[31:24];
            3'd2: b = arg[23:16];
            3'd3: b = arg[15:8];
            3'd4: b = arg[7:0];
            default: begin
               if (cmd == CMD_GO_IDLE) b = CRC_GO_IDLE;
               else if (cmd == CMD_IF_COND) b = CRC_IF_COND;
               else b = CRC_OTHER;
            end
         endcase
         return b;
      endfunction

      function logic [2:0] bytes_for_kind(logic [2:0] k);
         if (k == KIND_R1 || k == KIND_R1B) return 3'd1;
         if (k == KIND_R2) return 3'd2;
         if (k == KIND_R3 || k == KIND_R7) return 3'd5;
         return 3'd0;
      endfunction

      // another exchange with chip select held
      function result_type more(logic [7:0] b);
         result_type r;
         r = '0;
         r.tx_valid    = 1'b1;
         r.tx_byte     = b;
         r.chip_select = 1'b1;
         return r;
      endfunction

      function result_type close_exchange();
         result_type r;
         r = '0;
         r.done_res       = 1'b1;
         r.response_data  = gathered;
         r.response_count = byte_pos;
         phase = PH_IDLE;
         return r;
      endfunction

      function result_type predict_step(item_type it);
         result_type r;
         logic [2:0] len;
         r = '0;
         if (it.operation == OP_START) begin
            // a start always wins, even over a running exchange
            cmd        = it.command_index;
            arg        = it.argument_value;
            kind       = it.response_kind;
            phase      = PH_SEND;
            byte_pos   = '0;
            poll_count = '0;
            gathered   = '0;
            return more(frame_out(3'd0));
         end
         len = bytes_for_kind(kind);
         case (phase)
            PH_SEND: begin
               if (byte_pos < LAST_FRAME_POS) begin
                  byte_pos++;
                  r = more(frame_out(byte_pos));
               end else begin
                  phase      = PH_POLL;
                  poll_count = '0;
                  byte_pos   = '0;
                  r = more(FILLER_BYTE);
               end
            end
            PH_POLL: begin
               if (poll_count != POLL_MAX) poll_count++;
               if ((it.rx_byte & START_BIT_MASK) == 8'h00) begin
                  gathered = '0;
                  byte_pos = '0;
                  if (len == 3'd0) begin
                     r = close_exchange();
                  end else begin
                     gathered[7:0] = it.rx_byte;
                     byte_pos      = 3'd1;
                     phase         = PH_GATHER;
                     r = more(FILLER_BYTE);
                  end
               end else if (poll_count >= timeout_limit) begin
                  phase     = PH_IDLE;
                  byte_pos  = '0;
                  gathered  = '0;
                  r.done_res  = 1'b1;
                  r.timed_out = 1'b1;
               end else begin
                  r = more(FILLER_BYTE);
               end
            end
            PH_GATHER: begin
               if (byte_pos < len && byte_pos < MAX_RESP_BYTES) begin
                  gathered[8*byte_pos +: 8] = it.rx_byte;
                  byte_pos++;
                  r = more(FILLER_BYTE);
               end else if (kind == KIND_R1B) begin
                  phase = PH_BUSY;
                  r = more(FILLER_BYTE);
               end else begin
                  r = close_exchange();
               end
            end
            PH_BUSY: begin
               if (it.rx_byte == FILLER_BYTE) phase = PH_FINAL;
               r = more(FILLER_BYTE);
            end
            PH_FINAL: r = close_exchange();
            default: begin
               phase = PH_IDLE;
               r = '0;
            end
         endcase
         return r;
      endfunction

      function void note_request(item_type it);
         result_type r;
         r = predict_step(it);
         if (r.done_res) begin
            done_count++;
            if (r.timed_out) timeout_count++;
            else length_hist[r.response_count]++;
         end
         pending_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [39:0] want, logic [39:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("mismatch in response beat %0d, %s: expected %0h, got %0h",
                        beats_checked, name, want, got);
         end
      endfunction

      function void check_beat(logic [RSP_TDATA_W-1:0] d);
         result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("response beat with nothing pending: %0h", d);
            return;
         end
         want = pending_results.pop_front();
         compare_field("tx_valid", 40'(want.tx_valid), 40'(d[0]));
         compare_field("tx_byte", 40'(want.tx_byte), 40'(d[8:1]));
         compare_field("chip_select", 40'(want.chip_select), 40'(d[9]));
         compare_field("done_res", 40'(want.done_res), 40'(d[10]));
         compare_field("timed_out", 40'(want.timed_out), 40'(d[11]));
         compare_field("response_data", want.response_data, d[51:12]);
         compare_field("response_count", 40'(want.response_count), 40'(d[54:52]));
         compare_field("zero fill", 40'd0, 40'(d[RSP_TDATA_W-1:55]));
         beats_checked++;
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // dut and its signals
   // -------------------------------------------------------------------------
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = OP_START;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wr_en = 1'b0;
   logic [15:0]            csr_wr_data = '0;

   sd_spi_command_engine dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   spi_exchange_checker tracker;

   int   cycle_count = 0;
   int   beats_sent = 0;     // idle reports are not counted
   int   exchanges = 0;
   int   burst_left = 0;
   bit   sender_steady = 1'b0;
   bit   receiver_steady = 1'b0;
   int   stall_mode = 0;
   int   stall_left = 0;
   logic [7:0] stall_word = 8'h01;

   always #CLK_HALF clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("run limit of %0d cycles reached", CYCLE_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   // receiver: the stall mode is picked anew at random whenever its run ends
   // mode 0 always ready, 1 mostly ready, 2 rotating bit pattern, 3 mostly stalled
   always @(negedge clock) begin
      if (receiver_steady) begin
         rsp_tready <= 1'b1;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
            stall_word = 8'($urandom) | 8'h01;
         end
         stall_left--;
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: begin
               rsp_tready <= stall_word[0];
               stall_word = {stall_word[0], stall_word[7:1]};
            end
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // response beats are checked where they are accepted
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_beat(rsp_tdata);
   end

   // -------------------------------------------------------------------------
   // request side tasks
   // -------------------------------------------------------------------------

   // one request beat; tvalid stays up across a burst, drops for the gaps
   task automatic send_beat(input item_type it);
      int gap;
      bit ignored;
      if (burst_left == 0) begin
         if (sender_steady) gap = 0;
         else if ($urandom_range(0, 3) == 0) gap = $urandom_range(4, 9);
         else gap = $urandom_range(0, 2);
         if (gap != 0) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = sender_steady ? 64 : $urandom_range(1, 12);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = it.operation;
      req_tdata  = {7'b0, it.rx_byte, it.response_kind, it.argument_value,
                    it.command_index};
      do @(posedge clock); while (!req_tready);
      // a report with no exchange running gives an all-zero beat and is not counted
      ignored = (it.operation == OP_REPORT) && (tracker.phase == PH_IDLE);
      tracker.note_request(it);
      if (!ignored) beats_sent++;
   endtask

   task automatic start_command(input logic [5:0] c, input logic [31:0] a,
                                input logic [2:0] k);
      item_type it;
      it = '0;
      it.operation      = OP_START;
      it.command_index  = c;
      it.argument_value = a;
      it.response_kind  = k;
      it.rx_byte        = 8'($urandom);
      exchanges++;
      send_beat(it);
   endtask

   // unused fields of a report carry noise
   task automatic report_byte(input logic [7:0] rx);
      item_type it;
      it.operation      = OP_REPORT;
      it.command_index  = 6'($urandom);
      it.argument_value = $urandom;
      it.response_kind  = 3'($urandom);
      it.rx_byte        = rx;
      send_beat(it);
   endtask

   // let the pipe empty before touching the register
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [15:0] value);
      wait_drained();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      tracker.timeout_limit = value;
   endtask

   // one command exchange with random content, steered by the predicted phase
   task automatic run_exchange();
      logic [5:0]  c;
      logic [31:0] a;
      logic [2:0]  k;
      logic [7:0]  rx;
      int          wait_polls;
      int          busy_polls;
      int          polls_done;
      int          busy_done;
      int          sel;
      int          tl;
      case ($urandom_range(0, 5))
         0: c = CMD_GO_IDLE;
         1: c = CMD_IF_COND;
         2: c = CMD_INDEX_MASK;
         default: c = 6'($urandom);
      endcase
      case ($urandom_range(0, 5))
         0: a = '0;
         1: a = '1;
         default: a = $urandom;
      endcase
      // unknown kinds now and then
      k = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      tl  = int'(tracker.timeout_limit);
      sel = $urandom_range(0, 9);
      if (sel < 6) wait_polls = $urandom_range(0, 2);
      else if (tl <= 120 && sel == 6) wait_polls = tl - 1;  // start bit on the last try
      else if (tl <= 120 && sel < 9) wait_polls = tl;       // every try used up
      else wait_polls = $urandom_range(3, 10);
      busy_polls = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      polls_done = 0;
      busy_done  = 0;
      start_command(c, a, k);
      while (tracker.phase != PH_IDLE) begin
         // drop out now and then so the next start lands mid-exchange
         if ($urandom_range(0, 59) == 0) return;
         case (tracker.phase)
            PH_POLL: begin
               if (polls_done < wait_polls) begin
                  if ($urandom_range(0, 1) == 0) rx = FILLER_BYTE;
                  else rx = START_BIT_MASK | 8'($urandom_range(0, 127));
               end else if ($urandom_range(0, 3) == 0) begin
                  rx = 8'h00;
               end else begin
                  rx = 8'($urandom_range(0, 127));
               end
               polls_done++;
            end
            PH_BUSY: begin
               if (busy_done < busy_polls) rx = 8'($urandom_range(0, 254));
               else rx = FILLER_BYTE;
               busy_done++;
            end
            default: rx = 8'($urandom);
         endcase
         report_byte(rx);
      end
   endtask

   // -------------------------------------------------------------------------
   // test sequence
   // -------------------------------------------------------------------------
   initial begin
      int target;
      logic [15:0] setting;
      tracker = new();

      // synchronous reset
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: report with nothing running gives an all-zero beat
      report_byte(FILLER_BYTE);
      // go-idle command with its own crc, one filler poll, then a zero r1
      start_command(CMD_GO_IDLE, 32'h0000_0000, KIND_R1);
      report_byte(8'h00);
      report_byte(8'hFF);
      report_byte(8'h00);
      report_byte(8'hFF);
      report_byte(8'h00);
      report_byte(8'hFF);
      report_byte(FILLER_BYTE);
      report_byte(8'h00);
      report_byte(8'hFF);
      // interface condition command, all-ones argument, dropped mid-frame
      start_command(CMD_IF_COND, 32'hFFFF_FFFF, KIND_R7);
      report_byte(8'hFF);
      report_byte(8'hFF);
      // the start below replaces it; unknown kind ends on the start-bit byte
      start_command(CMD_INDEX_MASK, 32'hA5A5_5A5A, 3'd7);
      repeat (6) report_byte(FILLER_BYTE);
      report_byte(8'h7F);

      // random exchanges over a sweep of timeout settings
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: setting = 16'd1;
            1: setting = 16'hFFFF;
            2: setting = 16'd2;
            3: setting = TIMEOUT_RESET;
            4: setting = 16'($urandom_range(3, 12));
            5: setting = 16'($urandom_range(13, 60));
            6: setting = 16'($urandom_range(1, 65535));
            default: setting = 16'd3;
         endcase
         write_timeout(setting);
         target = beats_sent + RANDOM_BEATS / RANDOM_PHASES;
         while (beats_sent < target) begin
            if ($urandom_range(0, 7) == 0 && tracker.phase == PH_IDLE)
               report_byte(8'($urandom));
            run_exchange();
         end
      end

      // every poll tried until timeout, no idling on either side
      write_timeout(STEADY_TIMEOUT);
      sender_steady   = 1'b1;
      receiver_steady = 1'b1;
      start_command(6'($urandom), $urandom, KIND_R1);
      while (tracker.phase != PH_IDLE) report_byte(FILLER_BYTE);
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.pending_results.size() != 0) begin
         $display("%0d response beats never arrived", tracker.pending_results.size());
         tracker.mismatches += tracker.pending_results.size();
      end

      $display("%0d exchanges, %0d ended (%0d timed out), lengths 0/1/2/5: %0d/%0d/%0d/%0d",
               exchanges, tracker.done_count, tracker.timeout_count,
               tracker.length_hist[0], tracker.length_hist[1], tracker.length_hist[2],
               tracker.length_hist[5]);
      $display("timeouts swept 1..65535; %0d beats, %0d checked, %0d mismatches",
               beats_sent, tracker.beats_checked, tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/sdsc_pkg.sv
design/sdsc_in_reg.sv
design/sdsc_core.sv
design/sdsc_out_reg.sv
design/sd_spi_command_engine.sv
dv/tb_top.sv
